// ----- hdl/oau_pkg.sv -----
// ----------------------------------------------------------------------------
// oau_pkg
// Access kind codes and widths for the operand address unit.
// ----------------------------------------------------------------------------
package oau_pkg;

  localparam int unsigned KindW = 5;
  localparam int unsigned AddrW = 24;
  localparam int unsigned WordW = 16;
  localparam int unsigned ByteW = 8;

  typedef enum logic [KindW-1:0] {
    KIND_READ_PC          = 5'd0,
    KIND_READ_STACK       = 5'd1,
    KIND_READ_STACK_NAT   = 5'd2,
    KIND_READ_ADDR        = 5'd3,
    KIND_READ_LONG        = 5'd4,
    KIND_READ_DBR         = 5'd5,
    KIND_READ_PBR         = 5'd6,
    KIND_READ_DP          = 5'd7,
    KIND_READ_SP          = 5'd8,
    KIND_WRITE_STACK      = 5'd9,
    KIND_WRITE_STACK_NAT  = 5'd10,
    KIND_WRITE_ADDR       = 5'd11,
    KIND_WRITE_LONG       = 5'd12,
    KIND_WRITE_DBR        = 5'd13,
    KIND_WRITE_PBR        = 5'd14,
    KIND_WRITE_DP         = 5'd15,
    KIND_WRITE_SP         = 5'd16
  } kind_e;

  typedef struct packed {
    logic [KindW-1:0] opcode;
    logic [AddrW-1:0] operand_address;
    logic [ByteW-1:0] write_byte;
    logic             emulation;
    logic [WordW-1:0] direct_page;
    logic [ByteW-1:0] data_bank;
    logic [ByteW-1:0] program_bank;
    logic [WordW-1:0] program_counter;
    logic [WordW-1:0] stack_pointer;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0] bus_address;
    logic             rom_fetch;
    logic             is_write;
    logic [ByteW-1:0] store_byte;
    logic [WordW-1:0] next_stack_pointer;
    logic [WordW-1:0] next_program_counter;
  } rsp_t;

endpackage

// ----- hdl/cpu65816_operand_address_unit.sv -----
// ----------------------------------------------------------------------------
// cpu65816_operand_address_unit
// Effective address generation for byte accesses of a 65816 core.
//
//   channel  dir  handshake               payload
//   in       in   in_valid_i/in_ready_o   opcode .. stack_pointer
//   out      out  out_valid_o/out_ready_i bus_address .. next_program_counter
//
// Two register stages: request register, then result register. A transfer in
// is registered in the request register and its result in the result register;
// one item per cycle sustained while out_ready_i is held high.
// The address adders and muxes sit between the two stages.
// Each stage takes a new item when empty or when its content moves on, so the
// request register holds one item while a result waits at the output.
// Reset clears both stage valid flags.
// ----------------------------------------------------------------------------
module cpu65816_operand_address_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [oau_pkg::KindW-1:0]   opcode_i,
  input  logic [oau_pkg::AddrW-1:0]   operand_address_i,
  input  logic [oau_pkg::ByteW-1:0]   write_byte_i,
  input  logic                        emulation_i,
  input  logic [oau_pkg::WordW-1:0]   direct_page_i,
  input  logic [oau_pkg::ByteW-1:0]   data_bank_i,
  input  logic [oau_pkg::ByteW-1:0]   program_bank_i,
  input  logic [oau_pkg::WordW-1:0]   program_counter_i,
  input  logic [oau_pkg::WordW-1:0]   stack_pointer_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [oau_pkg::AddrW-1:0]   bus_address_o,
  output logic                        rom_fetch_o,
  output logic                        is_write_o,
  output logic [oau_pkg::ByteW-1:0]   store_byte_o,
  output logic [oau_pkg::WordW-1:0]   next_stack_pointer_o,
  output logic [oau_pkg::WordW-1:0]   next_program_counter_o
);
  import oau_pkg::*;

  logic req_valid_q, rsp_valid_q;
  req_t req_q;
  rsp_t rsp_q, rsp_d;
  logic rsp_load, req_load;

  assign rsp_load   = req_valid_q && (!rsp_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || rsp_load;
  assign req_load   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        req_valid_q <= in_valid_i;
      end
      if (!rsp_valid_q || out_ready_i) begin
        rsp_valid_q <= req_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_load) begin
      req_q.opcode          <= opcode_i;
      req_q.operand_address <= operand_address_i;
      req_q.write_byte      <= write_byte_i;
      req_q.emulation       <= emulation_i;
      req_q.direct_page     <= direct_page_i;
      req_q.data_bank       <= data_bank_i;
      req_q.program_bank    <= program_bank_i;
      req_q.program_counter <= program_counter_i;
      req_q.stack_pointer   <= stack_pointer_i;
    end
    if (rsp_load) begin
      rsp_q <= rsp_d;
    end
  end

  // address arithmetic
  logic [WordW-1:0] s_inc, s_dec, s_inc_emu, s_dec_emu, dp_sum, sp_sum;
  logic [AddrW-1:0] dbr_sum;
  logic             dp_wrap;

  always_comb begin
    s_inc     = req_q.stack_pointer + WordW'(1);
    s_dec     = req_q.stack_pointer - WordW'(1);
    s_inc_emu = {req_q.stack_pointer[WordW-1:ByteW], s_inc[ByteW-1:0]};
    s_dec_emu = {req_q.stack_pointer[WordW-1:ByteW], s_dec[ByteW-1:0]};
    dp_sum    = req_q.direct_page + req_q.operand_address[WordW-1:0];
    sp_sum    = req_q.stack_pointer + req_q.operand_address[WordW-1:0];
    dbr_sum   = {req_q.data_bank, {WordW{1'b0}}} + req_q.operand_address;
    dp_wrap   = req_q.emulation && (req_q.direct_page[ByteW-1:0] == '0);
  end

  always_comb begin
    rsp_d.bus_address          = '0;
    rsp_d.rom_fetch            = 1'b0;
    rsp_d.is_write             = 1'b0;
    rsp_d.store_byte           = '0;
    rsp_d.next_stack_pointer   = req_q.stack_pointer;
    rsp_d.next_program_counter = req_q.program_counter;
    unique case (kind_e'(req_q.opcode))
      KIND_READ_PC: begin
        rsp_d.rom_fetch            = 1'b1;
        rsp_d.bus_address          = {2'b00, req_q.program_bank[6:0],
                                      req_q.program_counter[14:0]};
        rsp_d.next_program_counter = req_q.program_counter + WordW'(1);
      end
      KIND_READ_STACK: begin
        rsp_d.next_stack_pointer = req_q.emulation ? s_inc_emu : s_inc;
        rsp_d.bus_address        = {ByteW'(0), rsp_d.next_stack_pointer};
      end
      KIND_READ_STACK_NAT: begin
        rsp_d.next_stack_pointer = s_inc;
        rsp_d.bus_address        = {ByteW'(0), s_inc};
      end
      KIND_WRITE_STACK: begin
        rsp_d.next_stack_pointer = req_q.emulation ? s_dec_emu : s_dec;
        rsp_d.bus_address        = {ByteW'(0), req_q.stack_pointer};
      end
      KIND_WRITE_STACK_NAT: begin
        rsp_d.next_stack_pointer = s_dec;
        rsp_d.bus_address        = {ByteW'(0), req_q.stack_pointer};
      end
      KIND_READ_ADDR, KIND_WRITE_ADDR: begin
        rsp_d.bus_address = {ByteW'(0), req_q.operand_address[WordW-1:0]};
      end
      KIND_READ_LONG, KIND_WRITE_LONG: begin
        rsp_d.bus_address = req_q.operand_address;
      end
      KIND_READ_DBR, KIND_WRITE_DBR: begin
        rsp_d.bus_address = dbr_sum;
      end
      KIND_READ_PBR, KIND_WRITE_PBR: begin
        rsp_d.bus_address = {req_q.program_bank, req_q.operand_address[WordW-1:0]};
      end
      KIND_READ_DP, KIND_WRITE_DP: begin
        rsp_d.bus_address = dp_wrap ?
            {ByteW'(0), req_q.direct_page[WordW-1:ByteW], dp_sum[ByteW-1:0]} :
            {ByteW'(0), dp_sum};
      end
      KIND_READ_SP, KIND_WRITE_SP: begin
        rsp_d.bus_address = {ByteW'(0), sp_sum};
      end
      default: begin
      end
    endcase
    if (req_q.opcode >= KIND_WRITE_STACK && req_q.opcode <= KIND_WRITE_SP) begin
      rsp_d.is_write   = 1'b1;
      rsp_d.store_byte = req_q.write_byte;
    end
  end

  assign out_valid_o            = rsp_valid_q;
  assign bus_address_o          = rsp_q.bus_address;
  assign rom_fetch_o            = rsp_q.rom_fetch;
  assign is_write_o             = rsp_q.is_write;
  assign store_byte_o           = rsp_q.store_byte;
  assign next_stack_pointer_o   = rsp_q.next_stack_pointer;
  assign next_program_counter_o = rsp_q.next_program_counter;

  a_rom_is_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rom_fetch_o |-> !is_write_o)
    else $error("rom fetch flagged as write");

  a_read_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_write_o |-> store_byte_o == '0)
    else $error("store byte set on read");

  a_req_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q && !rsp_load |=> req_valid_q)
    else $error("request lost while output stalled");

  a_req_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_load |=> req_valid_q)
    else $error("transfer in not registered");

  a_rsp_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_load |=> rsp_valid_q)
    else $error("result not registered");

endmodule
